### hdl/gsch_pkg.sv
package gsch_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_W        = 32;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = 2 * DIFF_W;
    localparam int POS_W          = 10;
    localparam int COUNT_W        = 11;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [18:0] {
        ST_IDLE    = 19'b0000000000000000001,
        ST_RD1     = 19'b0000000000000000010,
        ST_RD2     = 19'b0000000000000000100,
        ST_S_CUR   = 19'b0000000000000001000,
        ST_S_CUR2  = 19'b0000000000000010000,
        ST_S_FETCH = 19'b0000000000000100000,
        ST_S_B1    = 19'b0000000000001000000,
        ST_S_B2    = 19'b0000000000010000000,
        ST_DIFF    = 19'b0000000000100000000,
        ST_MUL     = 19'b0000000001000000000,
        ST_ACC     = 19'b0000000010000000000,
        ST_S_INS   = 19'b0000000100000000000,
        ST_H_CUR   = 19'b0000001000000000000,
        ST_H_A     = 19'b0000010000000000000,
        ST_H_B     = 19'b0000100000000000000,
        ST_H_POP1  = 19'b0001000000000000000,
        ST_H_POP2  = 19'b0010000000000000000,
        ST_H_POP3  = 19'b0100000000000000000,
        ST_H_PUSH  = 19'b1000000000000000000
    } state_t;

endpackage

### hdl/graham_scan_convex_hull.sv
// Loads are accepted back to back while the block is idle; they produce no beat.
// A read passes through ST_RD1 and ST_RD2, then returns its beat from registers.
// A last load starts an insertion sort and a stack scan over the point memory;
// each comparison runs on the one shared multiplier, and the sort costs up to
// n*(n-1)/2 comparisons before the scan; then the result beat appears.
// Reset (rst_n low, asynchronous) empties the set and the hull; memories are not cleared.
module graham_scan_convex_hull
    import gsch_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       opcode,
    input  logic signed [COORD_W-1:0]  point_x,
    input  logic signed [COORD_W-1:0]  point_y,
    input  logic                       last_point,
    input  logic        [POS_W-1:0]    hull_position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic        [COUNT_W-1:0]  hull_count,
    output logic        [POS_W-1:0]    vertex_index,
    output logic signed [COORD_W-1:0]  vertex_x,
    output logic signed [COORD_W-1:0]  vertex_y,
    output logic                       in_range,
    output logic                       overflow
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Memories: points as {y, x}, sorted order, hull stack.
    logic [2*COORD_W-1:0] pt_mem [MAX_POINTS];
    logic [IW-1:0]        ao_mem [MAX_POINTS];
    logic [IW-1:0]        hs_mem [MAX_POINTS];

    logic [2*COORD_W-1:0] pt_rdata_reg;
    logic [IW-1:0]        ao_rdata_reg;
    logic [IW-1:0]        hs_rdata_reg;

    logic                 pt_we, ao_we, hs_we;
    logic [IW-1:0]        pt_waddr, ao_waddr, hs_waddr;
    logic [2*COORD_W-1:0] pt_wdata;
    logic [IW-1:0]        ao_wdata, hs_wdata;
    logic [IW-1:0]        pt_raddr, ao_raddr, hs_raddr;

    // Control state.
    state_t        state_reg, state_next;
    logic [CW-1:0] loaded_count_reg, loaded_count_next;
    logic [CW-1:0] stack_count_reg, stack_count_next;
    logic          overflow_reg, overflow_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic [2:0]    mstep_reg, mstep_next;
    logic          scan_reg, scan_next;

    // Datapath state.
    logic signed [COORD_W-1:0] pvx_reg, pvx_next, pvy_reg, pvy_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [COORD_W-1:0] t0x_reg, t0x_next, t0y_reg, t0y_next;
    logic signed [COORD_W-1:0] t1x_reg, t1x_next, t1y_reg, t1y_next;
    logic [IW-1:0]             b_idx_reg, b_idx_next;
    logic [IW-1:0]             cur_idx_reg, cur_idx_next;
    logic signed [DIFF_W-1:0]  dxa_reg, dxa_next, dya_reg, dya_next;
    logic signed [DIFF_W-1:0]  dxb_reg, dxb_next, dyb_reg, dyb_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  p1_reg, p1_next;
    logic        [PROD_W-1:0]  da_reg, da_next, db_reg, db_next;
    logic                      pos_ok_reg, pos_ok_next;

    logic [COUNT_W-1:0]        hull_count_reg, hull_count_next;
    logic [POS_W-1:0]          vertex_index_reg, vertex_index_next;
    logic signed [COORD_W-1:0] vertex_x_reg, vertex_x_next;
    logic signed [COORD_W-1:0] vertex_y_reg, vertex_y_next;
    logic                      in_range_reg, in_range_next;
    logic                      ovf_out_reg, ovf_out_next;

    logic                      accept;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic        [PROD_W-1:0]  db_sum;
    logic                      take;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && (opcode || last_point));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    assign hull_count   = hull_count_reg;
    assign vertex_index = vertex_index_reg;
    assign vertex_x     = vertex_x_reg;
    assign vertex_y     = vertex_y_reg;
    assign in_range     = in_range_reg;
    assign overflow     = ovf_out_reg;

    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin mul_a = dxa_reg; mul_b = dyb_reg; end
            3'd1:    begin mul_a = dya_reg; mul_b = dxb_reg; end
            3'd2:    begin mul_a = dxa_reg; mul_b = dxa_reg; end
            3'd3:    begin mul_a = dya_reg; mul_b = dya_reg; end
            3'd4:    begin mul_a = dxb_reg; mul_b = dxb_reg; end
            default: begin mul_a = dyb_reg; mul_b = dyb_reg; end
        endcase
    end

    assign db_sum = db_reg + prod_reg[PROD_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        stack_count_next  = stack_count_reg;
        overflow_next     = overflow_reg;
        out_valid_next    = out_valid_reg && out_stall;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        sc_next           = sc_reg;
        mstep_next        = mstep_reg;
        scan_next         = scan_reg;
        pvx_next = pvx_reg;  pvy_next = pvy_reg;
        cx_next  = cx_reg;   cy_next  = cy_reg;
        bx_next  = bx_reg;   by_next  = by_reg;
        t0x_next = t0x_reg;  t0y_next = t0y_reg;
        t1x_next = t1x_reg;  t1y_next = t1y_reg;
        b_idx_next   = b_idx_reg;
        cur_idx_next = cur_idx_reg;
        dxa_next = dxa_reg;  dya_next = dya_reg;
        dxb_next = dxb_reg;  dyb_next = dyb_reg;
        prod_next = mul_a * mul_b;
        p1_next   = p1_reg;
        da_next   = da_reg;
        db_next   = db_reg;
        pos_ok_next       = pos_ok_reg;
        hull_count_next   = hull_count_reg;
        vertex_index_next = vertex_index_reg;
        vertex_x_next     = vertex_x_reg;
        vertex_y_next     = vertex_y_reg;
        in_range_next     = in_range_reg;
        ovf_out_next      = ovf_out_reg;
        take = 1'b0;

        pt_we = 1'b0; pt_waddr = loaded_count_reg[IW-1:0]; pt_wdata = {point_y, point_x};
        ao_we = 1'b0; ao_waddr = j_reg[IW-1:0];            ao_wdata = b_idx_reg;
        hs_we = 1'b0; hs_waddr = sc_reg[IW-1:0];           hs_wdata = cur_idx_reg;
        pt_raddr = i_reg[IW-1:0];
        ao_raddr = i_reg[IW-1:0];
        hs_raddr = IW'(hull_position);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_READ) begin
                    pos_ok_next = (32'(hull_position) < 32'(stack_count_reg))
                               && (32'(hull_position) < MAX_POINTS);
                    state_next  = ST_RD1;
                end else if (accept) begin
                    overflow_next = (loaded_count_reg == '0) ? 1'b0 : overflow_reg;
                    if (32'(loaded_count_reg) < MAX_POINTS) begin
                        pt_we = 1'b1;
                        loaded_count_next = loaded_count_reg + 1'b1;
                        // Pivot tracks the least point (x, then y), earliest on ties.
                        if (loaded_count_reg == '0 || point_x < pvx_reg
                            || (point_x == pvx_reg && point_y < pvy_reg)) begin
                            pvx_next = point_x;
                            pvy_next = point_y;
                        end
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (last_point) begin
                        n_next            = loaded_count_next;
                        loaded_count_next = '0;
                        i_next            = '0;
                        scan_next         = 1'b0;
                        state_next        = ST_S_CUR;
                    end
                end
            end
            ST_RD1:
            begin
                cur_idx_next = hs_rdata_reg;
                pt_raddr     = hs_rdata_reg;
                state_next   = ST_RD2;
            end
            ST_RD2:
            begin
                hull_count_next = COUNT_W'(stack_count_reg);
                ovf_out_next    = overflow_reg;
                in_range_next   = pos_ok_reg;
                if (pos_ok_reg) begin
                    vertex_index_next = POS_W'(cur_idx_reg);
                    vertex_x_next     = pt_rdata_reg[COORD_W-1:0];
                    vertex_y_next     = pt_rdata_reg[2*COORD_W-1:COORD_W];
                end else begin
                    vertex_index_next = '0;
                    vertex_x_next     = '0;
                    vertex_y_next     = '0;
                end
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_S_CUR:
            begin
                if (i_reg == n_reg) begin
                    sc_next    = '0;
                    i_next     = '0;
                    scan_next  = 1'b1;
                    state_next = ST_H_CUR;
                end else begin
                    j_next     = i_reg;
                    state_next = ST_S_CUR2;
                end
            end
            ST_S_CUR2:
            begin
                cx_next    = pt_rdata_reg[COORD_W-1:0];
                cy_next    = pt_rdata_reg[2*COORD_W-1:COORD_W];
                state_next = ST_S_FETCH;
            end
            ST_S_FETCH:
            begin
                ao_raddr   = IW'(j_reg - 1'b1);
                state_next = (j_reg == '0) ? ST_S_INS : ST_S_B1;
            end
            ST_S_B1:
            begin
                b_idx_next = ao_rdata_reg;
                pt_raddr   = ao_rdata_reg;
                state_next = ST_S_B2;
            end
            ST_S_B2:
            begin
                bx_next    = pt_rdata_reg[COORD_W-1:0];
                by_next    = pt_rdata_reg[2*COORD_W-1:COORD_W];
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                if (scan_reg) begin
                    dxa_next = DIFF_W'(t1x_reg) - DIFF_W'(t0x_reg);
                    dya_next = DIFF_W'(t1y_reg) - DIFF_W'(t0y_reg);
                    dxb_next = DIFF_W'(cx_reg)  - DIFF_W'(t0x_reg);
                    dyb_next = DIFF_W'(cy_reg)  - DIFF_W'(t0y_reg);
                end else begin
                    dxa_next = DIFF_W'(cx_reg) - DIFF_W'(pvx_reg);
                    dya_next = DIFF_W'(cy_reg) - DIFF_W'(pvy_reg);
                    dxb_next = DIFF_W'(bx_reg) - DIFF_W'(pvx_reg);
                    dyb_next = DIFF_W'(by_reg) - DIFF_W'(pvy_reg);
                end
                mstep_next = 3'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_MUL;
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    3'd0: p1_next = prod_reg;
                    3'd1:
                    begin
                        if (scan_reg) begin
                            // Pop while the turn is not strictly to the left.
                            if (p1_reg <= prod_reg) begin
                                sc_next  = sc_reg - 1'b1;
                                t1x_next = t0x_reg;
                                t1y_next = t0y_reg;
                                state_next = (sc_reg > CW'(2)) ? ST_H_POP1 : ST_H_PUSH;
                            end else begin
                                state_next = ST_H_PUSH;
                            end
                        end else if (p1_reg != prod_reg) begin
                            take = p1_reg > prod_reg;
                        end
                    end
                    3'd2: da_next = prod_reg[PROD_W-1:0];
                    3'd3: da_next = da_reg + prod_reg[PROD_W-1:0];
                    3'd4: db_next = prod_reg[PROD_W-1:0];
                    default: take = da_reg < db_sum;
                endcase
                if (!scan_reg && (mstep_reg == 3'd5
                                  || (mstep_reg == 3'd1 && p1_reg != prod_reg))) begin
                    if (take) begin
                        ao_we      = 1'b1;
                        j_next     = j_reg - 1'b1;
                        state_next = ST_S_FETCH;
                    end else begin
                        state_next = ST_S_INS;
                    end
                end
            end
            ST_S_INS:
            begin
                ao_we      = 1'b1;
                ao_wdata   = i_reg[IW-1:0];
                i_next     = i_reg + 1'b1;
                pt_raddr   = IW'(i_reg + 1'b1);
                state_next = ST_S_CUR;
            end
            ST_H_CUR:
            begin
                if (i_reg == n_reg) begin
                    stack_count_next  = sc_reg;
                    hull_count_next   = COUNT_W'(sc_reg);
                    ovf_out_next      = overflow_reg;
                    vertex_index_next = '0;
                    vertex_x_next     = '0;
                    vertex_y_next     = '0;
                    in_range_next     = 1'b0;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end else begin
                    state_next = ST_H_A;
                end
            end
            ST_H_A:
            begin
                cur_idx_next = ao_rdata_reg;
                pt_raddr     = ao_rdata_reg;
                state_next   = ST_H_B;
            end
            ST_H_B:
            begin
                cx_next    = pt_rdata_reg[COORD_W-1:0];
                cy_next    = pt_rdata_reg[2*COORD_W-1:COORD_W];
                state_next = (sc_reg >= CW'(2)) ? ST_DIFF : ST_H_PUSH;
            end
            ST_H_POP1:
            begin
                hs_raddr   = IW'(sc_reg - CW'(2));
                state_next = ST_H_POP2;
            end
            ST_H_POP2:
            begin
                pt_raddr   = hs_rdata_reg;
                state_next = ST_H_POP3;
            end
            ST_H_POP3:
            begin
                t0x_next   = pt_rdata_reg[COORD_W-1:0];
                t0y_next   = pt_rdata_reg[2*COORD_W-1:COORD_W];
                state_next = ST_DIFF;
            end
            ST_H_PUSH:
            begin
                hs_we      = 1'b1;
                t0x_next   = t1x_reg;
                t0y_next   = t1y_reg;
                t1x_next   = cx_reg;
                t1y_next   = cy_reg;
                sc_next    = sc_reg + 1'b1;
                i_next     = i_reg + 1'b1;
                ao_raddr   = IW'(i_reg + 1'b1);
                state_next = ST_H_CUR;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (ao_we)
        begin
            ao_mem[ao_waddr] <= ao_wdata;
        end
        if (hs_we)
        begin
            hs_mem[hs_waddr] <= hs_wdata;
        end
        pt_rdata_reg <= pt_mem[pt_raddr];
        ao_rdata_reg <= ao_mem[ao_raddr];
        hs_rdata_reg <= hs_mem[hs_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            loaded_count_reg <= '0;
            stack_count_reg  <= '0;
            overflow_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            n_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            sc_reg           <= '0;
            mstep_reg        <= '0;
            scan_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            stack_count_reg  <= stack_count_next;
            overflow_reg     <= overflow_next;
            out_valid_reg    <= out_valid_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            sc_reg           <= sc_next;
            mstep_reg        <= mstep_next;
            scan_reg         <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pvx_reg <= pvx_next;  pvy_reg <= pvy_next;
        cx_reg  <= cx_next;   cy_reg  <= cy_next;
        bx_reg  <= bx_next;   by_reg  <= by_next;
        t0x_reg <= t0x_next;  t0y_reg <= t0y_next;
        t1x_reg <= t1x_next;  t1y_reg <= t1y_next;
        b_idx_reg   <= b_idx_next;
        cur_idx_reg <= cur_idx_next;
        dxa_reg <= dxa_next;  dya_reg <= dya_next;
        dxb_reg <= dxb_next;  dyb_reg <= dyb_next;
        prod_reg <= prod_next;
        p1_reg   <= p1_next;
        da_reg   <= da_next;
        db_reg   <= db_next;
        pos_ok_reg       <= pos_ok_next;
        hull_count_reg   <= hull_count_next;
        vertex_index_reg <= vertex_index_next;
        vertex_x_reg     <= vertex_x_next;
        vertex_y_reg     <= vertex_y_next;
        in_range_reg     <= in_range_next;
        ovf_out_reg      <= ovf_out_next;
    end

endmodule

### hdl/gsch_checker.sv
module gsch_checker
    import gsch_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       opcode,
    input logic                       last_point,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic        [COUNT_W-1:0]  hull_count,
    input logic        [POS_W-1:0]    vertex_index,
    input logic signed [COORD_W-1:0]  vertex_x,
    input logic signed [COORD_W-1:0]  vertex_y,
    input logic                       in_range
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hull_count)
            && $stable(vertex_index) && $stable(vertex_x) && $stable(vertex_y))
        else $error("result beat changed while stalled");

    // A miss carries zero vertex fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> vertex_index == '0 && vertex_x == '0 && vertex_y == '0)
        else $error("out of range read carried vertex data");

    // A hit implies a non-empty hull.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> hull_count != '0)
        else $error("in range read with empty hull");

    // The hull computation blocks the input right after the closing load.
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_LOAD && last_point |=> in_stall)
        else $error("input accepted during hull computation");

endmodule

bind graham_scan_convex_hull gsch_checker u_gsch_checker (.*);
